// ===== rtl/apt_pkg.sv =====
// Shared types and constants for the affine point transform unit.
// Holds the fixed-point format, request codes and the item structs.
// Depends on nothing; every other file imports it.
`default_nettype none

package apt_pkg;

	// Fixed-point format of coefficients and coordinates.
	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int FIELD_WIDTH = 32;

	// Coefficient store: rows 0 to 3 by columns 0 to 2.
	localparam int NUM_COEFFS = 12;
	localparam int NUM_COLS   = 3;
	localparam int IDX_WIDTH  = 4;

	// Width of one product after the fraction bits are dropped, and of the sum.
	localparam int PROD_WIDTH = 2 * COORD_WIDTH - FRAC_BITS;
	localparam int SUM_WIDTH  = PROD_WIDTH + 2;

	// Request codes.
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_POINT = 2'd1;
	localparam logic [1:0] REQ_DIR   = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;

	// Largest positive coordinate, used for saturation and for 1.0 when it does not fit.
	localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam coord_t COEFF_ONE = (FRAC_BITS <= COORD_WIDTH - 2) ?
		coord_t'(coord_t'(1) << FRAC_BITS) : COORD_MAX;

	// One input item.
	typedef struct packed {
		logic [1:0]                    req_type;
		logic [IDX_WIDTH-1:0]          coeff_index;
		logic signed [FIELD_WIDTH-1:0] coeff_value;
		logic signed [FIELD_WIDTH-1:0] in_x;
		logic signed [FIELD_WIDTH-1:0] in_y;
		logic signed [FIELD_WIDTH-1:0] in_z;
	} req_item_t;

	// One result item.
	typedef struct packed {
		logic signed [FIELD_WIDTH-1:0] out_x;
		logic signed [FIELD_WIDTH-1:0] out_y;
		logic signed [FIELD_WIDTH-1:0] out_z;
		logic                          sat_flag;
	} rsp_item_t;

	// Control from the pipeline sequencing to each output lane.
	typedef struct packed {
		logic load;
		logic add_trans;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/affine_point_transform_unit.sv =====
// Affine point transform unit: top level with coefficient store and pipeline control.
// Instantiates three apt_lane columns; depends on apt_pkg.
//
// Usage:
// Items arrive on the req channel (req_valid, req_stall, req) and results leave on
// the rsp channel (rsp_valid, rsp_stall, rsp). An item is taken at a clock edge
// where valid is high and stall is low.
// A write item loads one coefficient of the 4x3 matrix at the edge it is taken and
// produces no result; an index above 11 and request type 3 are dropped.
// A point item returns x*R0 + y*R1 + z*R2 + R3; a direction item omits R3. Sums
// saturate to 32 bits and sat_flag reports any clipped component.
// A result passes through the input register, the product register and the result
// register in turn before it shows on rsp.
// Throughput: one item per cycle while req_stall is low; nine multipliers work in
// parallel in the product stage, three per output column.
// Writes land in order with transforms: a transform uses the matrix as it stood
// when the transform was taken.
// Reset clears all valid flags and loads the identity matrix with zero translation.
// When rsp_stall is high the result holds; the two inner stages keep filling, and
// req_stall rises only once all three stages hold items.
`default_nettype none

module affine_point_transform_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  apt_pkg::req_item_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output apt_pkg::rsp_item_t rsp
);
	import apt_pkg::*;

	coord_t    coeff_q [NUM_COEFFS];
	logic      s1_valid, s1_point;
	coord_t    x_s1, y_s1, z_s1;
	logic      s2_valid;
	logic      out_adv, s2_adv, s1_adv;
	logic      accept, take_xform;
	lane_ctl_t lane_ctl;
	coord_t    lane_res [NUM_COLS];
	logic      lane_clip [NUM_COLS];

	// Stage advance: a stage moves when it is empty or the next one moves.
	assign out_adv   = !rsp_valid || !rsp_stall;
	assign s2_adv    = !s2_valid || out_adv;
	assign s1_adv    = !s1_valid || s2_adv;
	assign req_stall = !s1_adv;
	assign accept    = req_valid && s1_adv;
	assign take_xform = accept && ((req.req_type == REQ_POINT) || (req.req_type == REQ_DIR));

	// Coefficient store; writes apply at the edge the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFFS; i++) begin
				coeff_q[i] <= ((i == 0) || (i == 4) || (i == 8)) ? COEFF_ONE : '0;
			end
		end else if (accept && (req.req_type == REQ_WRITE)
			&& (req.coeff_index < IDX_WIDTH'(NUM_COEFFS))) begin
			coeff_q[req.coeff_index] <= req.coeff_value[COORD_WIDTH-1:0];
		end
	end

	// First stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_adv) begin
			s1_valid <= take_xform;
		end
	end

	// First stage payload: coordinates of the transform item.
	always_ff @(posedge clk) begin
		if (take_xform) begin
			s1_point <= (req.req_type == REQ_POINT);
			x_s1     <= req.in_x[COORD_WIDTH-1:0];
			y_s1     <= req.in_y[COORD_WIDTH-1:0];
			z_s1     <= req.in_z[COORD_WIDTH-1:0];
		end
	end

	// Second stage control; products are held inside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_adv) begin
			s2_valid <= s1_valid;
		end
	end

	assign lane_ctl.load      = s2_adv && s1_valid;
	assign lane_ctl.add_trans = s1_point;

	// One lane per output column.
	for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
		apt_lane u_lane (
			.clk     (clk),
			.ctl     (lane_ctl),
			.x       (x_s1),
			.y       (y_s1),
			.z       (z_s1),
			.coeff_x (coeff_q[c]),
			.coeff_y (coeff_q[NUM_COLS + c]),
			.coeff_z (coeff_q[2*NUM_COLS + c]),
			.trans   (coeff_q[3*NUM_COLS + c]),
			.res     (lane_res[c]),
			.clip    (lane_clip[c])
		);
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_adv) begin
			rsp_valid <= s2_valid;
		end
	end

	// Result register payload, sign-extended to the field width.
	always_ff @(posedge clk) begin
		if (out_adv && s2_valid) begin
			rsp.out_x    <= FIELD_WIDTH'(lane_res[0]);
			rsp.out_y    <= FIELD_WIDTH'(lane_res[1]);
			rsp.out_z    <= FIELD_WIDTH'(lane_res[2]);
			rsp.sat_flag <= lane_clip[0] || lane_clip[1] || lane_clip[2];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/apt_lane.sv =====
// One output column of the transform: three products, translation, saturating sum.
// Registers the shifted products in the second stage; the sum is combinational.
// Depends on apt_pkg.
`default_nettype none

module apt_lane (
	input  wire                clk,
	input  apt_pkg::lane_ctl_t ctl,
	input  apt_pkg::coord_t    x,
	input  apt_pkg::coord_t    y,
	input  apt_pkg::coord_t    z,
	input  apt_pkg::coord_t    coeff_x,
	input  apt_pkg::coord_t    coeff_y,
	input  apt_pkg::coord_t    coeff_z,
	input  apt_pkg::coord_t    trans,
	output apt_pkg::coord_t    res,
	output logic               clip
);
	import apt_pkg::*;

	logic signed [2*COORD_WIDTH-1:0] full_x, full_y, full_z;
	prod_t  px_s2, py_s2, pz_s2;
	coord_t trans_s2;
	sum_t   sum;
	logic   over;

	// Full products; dropping the low fraction bits is a floor shift.
	assign full_x = x * coeff_x;
	assign full_y = y * coeff_y;
	assign full_z = z * coeff_z;

	// Second stage: shifted products and the translation term of this item.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			px_s2    <= full_x[2*COORD_WIDTH-1:FRAC_BITS];
			py_s2    <= full_y[2*COORD_WIDTH-1:FRAC_BITS];
			pz_s2    <= full_z[2*COORD_WIDTH-1:FRAC_BITS];
			trans_s2 <= ctl.add_trans ? trans : '0;
		end
	end

	// Exact sum in a width that cannot overflow.
	assign sum = sum_t'(px_s2) + sum_t'(py_s2) + sum_t'(pz_s2) + sum_t'(trans_s2);

	// The sum fits when every bit above the coordinate's sign bit matches it.
	assign over = (sum[SUM_WIDTH-1:COORD_WIDTH-1] != {(SUM_WIDTH-COORD_WIDTH+1){1'b0}})
		&& (sum[SUM_WIDTH-1:COORD_WIDTH-1] != {(SUM_WIDTH-COORD_WIDTH+1){1'b1}});

	always_comb begin
		clip = over;
		if (!over) begin
			res = sum[COORD_WIDTH-1:0];
		end else if (sum[SUM_WIDTH-1]) begin
			res = COORD_MIN;
		end else begin
			res = COORD_MAX;
		end
	end

endmodule

`default_nettype wire
